/* hdl/fbpb_pkg.sv */
`timescale 1ns / 1ps

package fbpb_pkg;

  // Pixel command codes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_COPY  = 2'd2,
    MODE_BLEND = 2'd3
  } mode_t;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOR  = 1'b1;

  // Register map
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BG_RED       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BG_GREEN     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BG_BLUE      = 2'd3;

  localparam int CW_W = 9;
  localparam logic [CW_W-1:0] CW_RESET = 9'd256;

  localparam logic [7:0] CHAN_MAX   = 8'hFF;
  localparam logic [7:0] ALPHA_NONE = 8'h00;

  // y * canvas_width + x stays below 2^17
  localparam int RAW_W  = 17;
  localparam int SCNT_W = 5;

  // Channels: [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [CW_W-1:0] canvas_width;
    logic [7:0]      bg_red;
    logic [7:0]      bg_green;
    logic [7:0]      bg_blue;
  } cfg_t;

endpackage

/* hdl/fbpb_if.sv */
`timescale 1ns / 1ps

interface fbpb_cmd_if;
  import fbpb_pkg::*;

  logic       valid;
  logic       ready;
  mode_t      mode;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;

  modport source (
    output valid, mode, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
    input  ready
  );
  modport sink (
    input  valid, mode, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
    output ready
  );
endinterface

interface fbpb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic [7:0] pix_alpha;
  logic       status;

  modport source (
    output valid, pix_red, pix_green, pix_blue, pix_alpha, status,
    input  ready
  );
  modport sink (
    input  valid, pix_red, pix_green, pix_blue, pix_alpha, status,
    output ready
  );
endinterface

/* hdl/fbpb_ram.sv */
`timescale 1ns / 1ps

module fbpb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fbpb_regs.sv */
`timescale 1ns / 1ps

module fbpb_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [fbpb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output fbpb_pkg::cfg_t         cfg
);
  import fbpb_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[REG_IDX_W+1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width <= CW_RESET;
      cfg.bg_red       <= '0;
      cfg.bg_green     <= '0;
      cfg.bg_blue      <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_CANVAS_WIDTH: cfg.canvas_width <= pwdata[CW_W-1:0];
        REG_BG_RED:       cfg.bg_red       <= pwdata[7:0];
        REG_BG_GREEN:     cfg.bg_green     <= pwdata[7:0];
        REG_BG_BLUE:      cfg.bg_blue      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CANVAS_WIDTH: prdata = 32'(cfg.canvas_width);
      REG_BG_RED:       prdata = 32'(cfg.bg_red);
      REG_BG_GREEN:     prdata = 32'(cfg.bg_green);
      REG_BG_BLUE:      prdata = 32'(cfg.bg_blue);
      default:          prdata = '0;
    endcase
  end

endmodule

/* hdl/fbpb_mix.sv */
`timescale 1ns / 1ps

// Source-over mix: products registered on load, sum and shift after.
module fbpb_mix (
  input  logic           clk,
  input  logic           load,
  input  fbpb_pkg::rgb_t dst,
  input  fbpb_pkg::rgb_t src,
  input  logic [7:0]     alpha,
  output fbpb_pkg::rgb_t mixed
);
  import fbpb_pkg::*;

  logic [2:0][15:0] prod_dst;
  logic [2:0][15:0] prod_src;
  logic [7:0]       inv_alpha;
  logic [2:0][15:0] sum;

  assign inv_alpha = CHAN_MAX - alpha;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < 3; c++) begin
        prod_dst[c] <= 16'(dst[c]) * 16'(inv_alpha);
        prod_src[c] <= 16'(src[c]) * 16'(alpha);
      end
    end
  end

  // The two products of one channel sum to at most 255*255, so 16 bits hold it
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c]   = prod_dst[c] + prod_src[c];
      mixed[c] = sum[c][15:8];
    end
  end

endmodule

/* hdl/framebuffer_pixel_blend_engine.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Contents
// cmd      in   valid/ready   mode, pos_x, pos_y, src_red/green/blue, src_alpha
// pix      out  valid/ready   pix_red/green/blue, pix_alpha (zero), status
// apb      in   psel/penable  canvas_width, bg_red, bg_green, bg_blue at 4*i
//
// One request at a time. An in-range request passes through these steps from
// accept until the next request can be taken: one conditional subtract
// per wrap step, pixel memory read, product register, write back, result
// hand-off, return to idle. The address multiply sits in the accept cycle.
// MOD_STEPS is 1 at the default 256x256 store. A request with the column at
// or beyond canvas_width skips to result hand-off and never touches memory.
// Reset clears control and config registers only; pixel memory is not cleared.
// A result that is not taken holds the next request in its final state.
module framebuffer_pixel_blend_engine #(
  parameter int FB_COLS = 256,
  parameter int FB_ROWS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  fbpb_cmd_if.sink               cmd,
  fbpb_pix_if.source             pix,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [fbpb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import fbpb_pkg::*;

  localparam int DEPTH  = FB_COLS * FB_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Number of shifted subtract steps that bring any raw address below DEPTH.
  function automatic int mod_steps(int depth);
    int s;
    s = 0;
    for (int k = 0; k < 32; k++) begin
      if ((64'(depth) << k) < (64'd1 << RAW_W)) begin
        s = k + 1;
      end
    end
    return s;
  endfunction

  localparam int MOD_STEPS = mod_steps(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_READ  = 6'b000100,
    S_MULT  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  cfg_t cfg;

  // Request held for the whole operation
  mode_t             mode;
  rgb_t              src;
  logic [7:0]        alpha;
  logic              oor;
  logic [RAW_W-1:0]  resid;
  logic [SCNT_W-1:0] step;
  rgb_t              dst;
  rgb_t              result;

  // Output register
  logic       out_valid;
  rgb_t       out_pix;
  logic       out_status;

  logic              accept;
  logic [31:0]       sub;
  logic [ADDR_W-1:0] addr;
  rgb_t              mixed;
  rgb_t              rd_data;
  rgb_t              bg;
  rgb_t              result_next;
  logic              free;

  fbpb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold ready low while reset is asserted so no request slips in
  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE) && !rst;

  // Shifted copy of the store depth for the current wrap step
  assign sub  = 32'(DEPTH) << step;
  assign addr = ADDR_W'(resid);
  assign bg   = {cfg.bg_red, cfg.bg_green, cfg.bg_blue};

  // Output register is free when empty or being drained this cycle
  assign free = !out_valid || pix.ready;

  fbpb_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    ((state == S_WRITE) && (mode != MODE_READ)),
    .waddr (addr),
    .wdata (result_next),
    .re    (state == S_READ),
    .raddr (addr),
    .rdata (rd_data)
  );

  fbpb_mix u_mix (
    .clk   (clk),
    .load  (state == S_MULT),
    .dst   (rd_data),
    .src   (src),
    .alpha (alpha),
    .mixed (mixed)
  );

  // New pixel value by command
  always_comb begin
    unique case (mode)
      MODE_READ:  result_next = dst;
      MODE_CLEAR: result_next = bg;
      MODE_COPY:  result_next = src;
      MODE_BLEND: result_next = mixed;
      default:    result_next = dst;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ({1'b0, cmd.pos_x} >= cfg.canvas_width) begin
              state <= S_DONE;
            end else if (MOD_STEPS != 0) begin
              state <= S_MOD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MOD: begin
          if (step == '0) begin
            state <= S_READ;
          end
        end
        S_READ:  state <= S_MULT;
        S_MULT:  state <= S_WRITE;
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode  <= cmd.mode;
      src   <= {cmd.src_red, cmd.src_green, cmd.src_blue};
      alpha <= cmd.src_alpha;
      oor   <= ({1'b0, cmd.pos_x} >= cfg.canvas_width);
      resid <= RAW_W'(RAW_W'(cmd.pos_y) * RAW_W'(cfg.canvas_width) + RAW_W'(cmd.pos_x));
      step  <= SCNT_W'(MOD_STEPS - 1);
    end
    // Wrap the address into the store, one shifted subtract per cycle
    if (state == S_MOD) begin
      if (32'(resid) >= sub) begin
        resid <= resid - RAW_W'(sub);
      end
      step <= step - SCNT_W'(1);
    end
    // Hold the stored pixel for the read command
    if (state == S_MULT) begin
      dst <= rd_data;
    end
    if (state == S_WRITE) begin
      result <= result_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && free) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && free) begin
      out_pix    <= oor ? rgb_t'('0) : result;
      out_status <= oor ? STATUS_OOR : STATUS_DONE;
    end
  end

  assign pix.valid     = out_valid;
  assign pix.pix_red   = out_pix[2];
  assign pix.pix_green = out_pix[1];
  assign pix.pix_blue  = out_pix[0];
  assign pix.pix_alpha = ALPHA_NONE;
  assign pix.status    = out_status;

endmodule
